### src/keyword_score_classifier_macros.svh
// Assertion macros for the keyword score classifier checker.
// No dependencies; included by the checker file only.
`ifndef KEYWORD_SCORE_CLASSIFIER_MACROS_SVH
`define KEYWORD_SCORE_CLASSIFIER_MACROS_SVH

// implication checked in the same cycle, masked while in reset
`define KSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the next cycle, not masked by reset
`define KSC_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/ksc_pkg.sv
// Shared types, constants and helpers for the keyword score classifier.
// No dependencies.
`timescale 1ns / 1ps

package ksc_pkg;

   localparam int NUM_KW   = 64;
   localparam int KW_LEN   = 16;
   localparam int NUM_CAT  = 16;
   localparam int KW_W     = 6;
   localparam int POS_W    = 4;
   localparam int LEN_W    = 5;
   localparam int CAT_W    = 4;
   localparam int CNT_W    = 7;
   localparam int SCORE_W  = 10;

   localparam logic [2:0] OP_CLEAR   = 3'd0;
   localparam logic [2:0] OP_KW_BYTE = 3'd1;
   localparam logic [2:0] OP_KW_DEF  = 3'd2;
   localparam logic [2:0] OP_CAT_ID  = 3'd3;
   localparam logic [2:0] OP_TEXT    = 3'd4;
   localparam logic [2:0] OP_END     = 3'd5;

   typedef struct packed {
      logic [2:0]  operation;
      logic [5:0]  kw_slot;
      logic [3:0]  char_pos;
      logic [7:0]  char_value;
      logic [4:0]  kw_length;
      logic [3:0]  cat_slot;
      logic [15:0] cat_id;
   } req_type;

   typedef struct packed {
      logic [15:0] best_id;
      logic [9:0]  best_score;
   } rsp_type;

   // decoded command: byte folded, length saturated
   typedef struct packed {
      logic [2:0]       op;
      logic [KW_W-1:0]  kw_slot;
      logic [POS_W-1:0] char_pos;
      logic [7:0]       value;
      logic [LEN_W-1:0] len;
      logic [CAT_W-1:0] cat_slot;
      logic [15:0]      cat_id;
   } cmd_type;

   function automatic logic [7:0] fold_lower(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

endpackage

### src/ksc_front.sv
// Front end: takes requests, decodes and normalises them into commands.
// Depends on ksc_pkg.
`timescale 1ns / 1ps

module ksc_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  ksc_pkg::req_type req_payload,
   input  logic             q_full,
   output logic             q_push,
   output ksc_pkg::cmd_type q_cmd
);

   logic known;

   always_comb begin
      unique case (req_payload.operation)
         ksc_pkg::OP_CLEAR, ksc_pkg::OP_KW_BYTE, ksc_pkg::OP_KW_DEF,
         ksc_pkg::OP_CAT_ID, ksc_pkg::OP_TEXT, ksc_pkg::OP_END: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   assign req_ready = !q_full;
   // unused codes are taken and dropped
   assign q_push    = req_valid && !q_full && known;

   always_comb begin
      q_cmd.op       = req_payload.operation;
      q_cmd.kw_slot  = req_payload.kw_slot;
      q_cmd.char_pos = req_payload.char_pos;
      q_cmd.value    = ksc_pkg::fold_lower(req_payload.char_value);
      q_cmd.len      = (req_payload.kw_length > 5'(ksc_pkg::KW_LEN)) ?
                       5'(ksc_pkg::KW_LEN) : req_payload.kw_length;
      q_cmd.cat_slot = req_payload.cat_slot;
      q_cmd.cat_id   = req_payload.cat_id;
   end

endmodule

### src/ksc_queue.sv
// Two-entry command queue between front and back end.
// Depends on ksc_pkg.
`timescale 1ns / 1ps

module ksc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ksc_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output ksc_pkg::cmd_type head
);

   ksc_pkg::cmd_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### src/ksc_back.sv
// Back end: keyword table memory, text history, match walk, scoring and
// result register. Depends on ksc_pkg.
`timescale 1ns / 1ps

module ksc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  ksc_pkg::cmd_type head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ksc_pkg::rsp_type rsp_payload
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MATCH = 3'd1;
   localparam logic [2:0] ST_COUNT = 3'd2;
   localparam logic [2:0] ST_BEST  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   localparam logic [ksc_pkg::KW_W-1:0]  KW_LAST  = ksc_pkg::KW_W'(ksc_pkg::NUM_KW - 1);
   localparam logic [ksc_pkg::CAT_W-1:0] CAT_LAST = ksc_pkg::CAT_W'(ksc_pkg::NUM_CAT - 1);

   typedef struct packed {
      logic [ksc_pkg::LEN_W-1:0]        len;
      logic [ksc_pkg::CAT_W-1:0]        owner;
      logic [ksc_pkg::KW_LEN-1:0][7:0]  bytes;
   } row_type;

   row_type kw_mem [ksc_pkg::NUM_KW];
   row_type rd_row_ff;
   row_type new_row;

   logic [2:0]                      state_ff, state_in;
   logic [ksc_pkg::NUM_KW-1:0]      kw_vld_ff;
   logic [ksc_pkg::NUM_KW-1:0]      hit_ff;
   logic [15:0]                     cat_id_ff [ksc_pkg::NUM_CAT];
   logic [7:0]                      hist_ff [ksc_pkg::KW_LEN];
   logic [ksc_pkg::LEN_W-1:0]       seen_ff;
   logic [ksc_pkg::CNT_W-1:0]       cnt_ff [ksc_pkg::NUM_CAT];
   logic [ksc_pkg::KW_W:0]          k_ff;
   logic                            rv_ff;
   logic [ksc_pkg::KW_W-1:0]        ridx_ff;
   logic [ksc_pkg::CAT_W-1:0]       c_ff;
   logic [ksc_pkg::CNT_W-1:0]       best_cnt_ff;
   logic [15:0]                     best_id_ff;
   logic                            rsp_valid_ff;
   ksc_pkg::rsp_type                rsp_ff;

   logic                            walking, issue, walk_done, emit;
   logic [ksc_pkg::LEN_W-1:0]       cur_len;
   logic                            is_match;
   logic [ksc_pkg::LEN_W-1:0]       hidx;
   logic [ksc_pkg::SCORE_W-1:0]     score;

   assign pop       = (state_ff == ST_IDLE) && !q_empty;
   assign walking   = (state_ff == ST_MATCH) || (state_ff == ST_COUNT);
   assign issue     = walking && (k_ff < 7'(ksc_pkg::NUM_KW));
   assign walk_done = rv_ff && (ridx_ff == KW_LAST);
   assign emit      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // row for a first write into an entry since reset or clear
   always_comb begin
      new_row = '0;
      if (head.op == ksc_pkg::OP_KW_BYTE) begin
         new_row.bytes[head.char_pos] = head.value;
      end else begin
         new_row.len   = head.len;
         new_row.owner = head.cat_slot;
      end
   end

   // compare the fetched keyword against the newest text bytes
   always_comb begin
      cur_len  = kw_vld_ff[ridx_ff] ? rd_row_ff.len : '0;
      is_match = (cur_len != '0) && (cur_len <= seen_ff);
      for (int i = 0; i < ksc_pkg::KW_LEN; i++) begin
         hidx = cur_len - 5'd1 - 5'(i);
         if (5'(i) < cur_len && rd_row_ff.bytes[i] != hist_ff[hidx[ksc_pkg::POS_W-1:0]]) begin
            is_match = 1'b0;
         end
      end
   end

   assign score = ({3'b0, best_cnt_ff} << 3) + ({3'b0, best_cnt_ff} << 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop && head.op == ksc_pkg::OP_TEXT) state_in = ST_MATCH;
            if (pop && head.op == ksc_pkg::OP_END)  state_in = ST_COUNT;
         end
         ST_MATCH: if (walk_done) state_in = ST_IDLE;
         ST_COUNT: if (walk_done) state_in = ST_BEST;
         ST_BEST:  if (c_ff == CAT_LAST) state_in = ST_EMIT;
         ST_EMIT:  if (emit) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // keyword table memory
   always_ff @(posedge clock) begin
      if (pop && head.op == ksc_pkg::OP_KW_BYTE) begin
         if (kw_vld_ff[head.kw_slot]) begin
            kw_mem[head.kw_slot].bytes[head.char_pos] <= head.value;
         end else begin
            kw_mem[head.kw_slot] <= new_row;
         end
      end else if (pop && head.op == ksc_pkg::OP_KW_DEF) begin
         if (kw_vld_ff[head.kw_slot]) begin
            kw_mem[head.kw_slot].len   <= head.len;
            kw_mem[head.kw_slot].owner <= head.cat_slot;
         end else begin
            kw_mem[head.kw_slot] <= new_row;
         end
      end
      if (issue) begin
         rd_row_ff <= kw_mem[k_ff[ksc_pkg::KW_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kw_vld_ff    <= '0;
         hit_ff       <= '0;
         seen_ff      <= '0;
         k_ff         <= '0;
         rv_ff        <= 1'b0;
         ridx_ff      <= '0;
         c_ff         <= '0;
         best_cnt_ff  <= '0;
         best_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ksc_pkg::NUM_CAT; i++) begin
            cat_id_ff[i] <= '0;
            cnt_ff[i]    <= '0;
         end
         for (int i = 0; i < ksc_pkg::KW_LEN; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rv_ff    <= issue;
         if (issue) begin
            ridx_ff <= k_ff[ksc_pkg::KW_W-1:0];
            k_ff    <= k_ff + 7'd1;
         end
         if (walk_done) begin
            k_ff <= '0;
         end

         if (pop) begin
            unique case (head.op)
               ksc_pkg::OP_CLEAR: begin
                  kw_vld_ff <= '0;
                  hit_ff    <= '0;
                  seen_ff   <= '0;
                  for (int i = 0; i < ksc_pkg::NUM_CAT; i++) begin
                     cat_id_ff[i] <= '0;
                  end
                  for (int i = 0; i < ksc_pkg::KW_LEN; i++) begin
                     hist_ff[i] <= '0;
                  end
               end
               ksc_pkg::OP_KW_BYTE: kw_vld_ff[head.kw_slot] <= 1'b1;
               ksc_pkg::OP_KW_DEF: begin
                  kw_vld_ff[head.kw_slot] <= 1'b1;
                  hit_ff[head.kw_slot]    <= 1'b0;
               end
               ksc_pkg::OP_CAT_ID: cat_id_ff[head.cat_slot] <= head.cat_id;
               ksc_pkg::OP_TEXT: begin
                  for (int i = ksc_pkg::KW_LEN - 1; i > 0; i--) begin
                     hist_ff[i] <= hist_ff[i-1];
                  end
                  hist_ff[0] <= head.value;
                  if (seen_ff < 5'(ksc_pkg::KW_LEN)) seen_ff <= seen_ff + 5'd1;
               end
               ksc_pkg::OP_END: begin
                  for (int i = 0; i < ksc_pkg::NUM_CAT; i++) begin
                     cnt_ff[i] <= '0;
                  end
               end
               default: ;
            endcase
         end

         if (state_ff == ST_MATCH && rv_ff && is_match) begin
            hit_ff[ridx_ff] <= 1'b1;
         end
         if (state_ff == ST_COUNT && rv_ff && hit_ff[ridx_ff] && cur_len != '0) begin
            cnt_ff[rd_row_ff.owner] <= cnt_ff[rd_row_ff.owner] + 7'd1;
         end
         if (state_ff == ST_COUNT && walk_done) begin
            c_ff        <= '0;
            best_cnt_ff <= '0;
            best_id_ff  <= '0;
         end

         // first category strictly above the running maximum wins
         if (state_ff == ST_BEST) begin
            c_ff <= c_ff + 4'd1;
            if (cnt_ff[c_ff] > best_cnt_ff) begin
               best_cnt_ff <= cnt_ff[c_ff];
               best_id_ff  <= cat_id_ff[c_ff];
            end
         end

         if (emit) begin
            rsp_valid_ff <= 1'b1;
            hit_ff       <= '0;
            seen_ff      <= '0;
            for (int i = 0; i < ksc_pkg::KW_LEN; i++) begin
               hist_ff[i] <= '0;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff.best_id    <= best_id_ff;
         rsp_ff.best_score <= score;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### src/keyword_score_classifier.sv
// Keyword score classifier: a request front end and a table/scoring back end
// joined by a two-entry command queue. Depends on ksc_pkg, ksc_front,
// ksc_queue and ksc_back.
//
// Table loads, category ids and clears are applied when the back end pops
// them. For a text byte the back end walks the 64 keyword rows of its table
// memory, one row per cycle, and compares each row against the last 16 text
// bytes. Text end walks the rows again to count hits per category, then
// steps through the 16 category slots picking the winner and loads the
// result register. The result waits in that register while the next
// requests are queued. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module keyword_score_classifier (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ksc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ksc_pkg::rsp_type rsp_payload
);

   logic             q_full, q_push, q_empty, q_pop;
   ksc_pkg::cmd_type q_cmd, q_head;

   ksc_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   ksc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   ksc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .head        (q_head),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### src/ksc_checker.sv
// Port-level checker for the keyword score classifier, bound to the top.
// Depends on ksc_pkg and keyword_score_classifier_macros.svh.
`timescale 1ns / 1ps
`include "keyword_score_classifier_macros.svh"

module ksc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ksc_pkg::rsp_type rsp_payload
);

   `KSC_ASSERT_NEXT(a_rst_no_rsp, clock, reset, !rsp_valid, "result shown after reset")
   `KSC_ASSERT_NEXT(a_rst_ready, clock, reset, req_ready, "requests refused after reset")
   `KSC_ASSERT_NOW(a_score_max, clock, reset, rsp_valid, rsp_payload.best_score <= 10'd640, "score above maximum")
   `KSC_ASSERT_NOW(a_no_hit_no_id, clock, reset, rsp_valid && rsp_payload.best_score == '0, rsp_payload.best_id == '0, "id reported without a hit")
   `KSC_ASSERT_NEXT(a_rsp_hold, clock, !reset && rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result changed")

endmodule

bind keyword_score_classifier ksc_checker u_ksc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
